// ----- hw/rtl/cdvc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdvc_pkg
// shared types and constants of the display value client
// ----------------------------------------------------------------------------
package cdvc_pkg;

  // default geometry of the presence map
  localparam int MAP_WORDS_DEF = 256;
  localparam int WORD_BITS_DEF = 16;

  // addresses are 12 bits, so the map never covers more than this
  localparam int ADDR_SPACE = 4096;
  localparam int ADDR_W     = 12;

  localparam logic [10:0] BASE_ID_RESET = 11'h6F0;

  // item kinds
  localparam logic [1:0] KIND_FRAME = 2'd0;
  localparam logic [1:0] KIND_NEXT  = 2'd1;
  localparam logic [1:0] KIND_GIVEN = 2'd2;

  // identifier offsets from base_id
  localparam logic [10:0] OFF_REPLY    = 11'd1;
  localparam logic [10:0] OFF_DESC1    = 11'd2;
  localparam logic [10:0] OFF_DESC2    = 11'd3;
  localparam logic [10:0] OFF_SUFFIX   = 11'd4;
  localparam logic [10:0] OFF_VALUE1   = 11'd5;
  localparam logic [10:0] OFF_VALUE2   = 11'd6;
  localparam logic [10:0] OFF_REGISTER = 11'd15;

  // text slot codes
  localparam logic [2:0] SLOT_NONE   = 3'd0;
  localparam logic [2:0] SLOT_DESC1  = 3'd1;
  localparam logic [2:0] SLOT_DESC2  = 3'd2;
  localparam logic [2:0] SLOT_SUFFIX = 3'd3;
  localparam logic [2:0] SLOT_VALUE1 = 3'd4;
  localparam logic [2:0] SLOT_VALUE2 = 3'd5;

  typedef struct packed {
    logic [1:0]  kind;
    logic [10:0] frame_id;
    logic [63:0] frame_data;
    logic [11:0] target_addr;
  } in_word_t;

  typedef struct packed {
    logic        request_send;
    logic [11:0] request_addr;
    logic        scan_found;
    logic        newly_registered;
    logic [2:0]  text_slot;
    logic [63:0] text_bytes;
    logic        reply_valid;
    logic        awaiting_reply;
    logic [7:0]  message_type;
    logic [7:0]  frame_type;
  } out_word_t;

endpackage

// ----- hw/rtl/cdvc_addr_split.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdvc_addr_split
// splits a map address into word index and bit index by a constant divisor
// ----------------------------------------------------------------------------
module cdvc_addr_split
  import cdvc_pkg::*;
#(
  parameter int MAP_WORDS = MAP_WORDS_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF,
  localparam int AW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1,
  localparam int BW       = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1
) (
  input  logic                 clk,
  input  logic [ADDR_W-1:0]    op,
  output logic [AW-1:0]        word_idx,
  output logic [ADDR_W-1:0]    word_base,
  output logic [BW-1:0]        bit_idx
);

  // reciprocal exact for 12-bit operands and divisors up to 64
  localparam int SH    = 18;
  localparam int RECIP = ((2 ** SH) + WORD_BITS - 1) / WORD_BITS;
  localparam int PW    = ADDR_W + SH + 1;

  logic [PW-1:0]  prod;
  logic [AW-1:0]  q_r;
  logic [18:0]    base_full;

  assign prod = PW'(op) * PW'(RECIP);

  always_ff @(posedge clk) begin
    q_r <= prod[SH +: AW];
  end

  // second step, after the register: base and remainder
  assign base_full = 19'(q_r) * 19'(WORD_BITS);
  assign word_idx  = q_r;
  assign word_base = base_full[ADDR_W-1:0];
  assign bit_idx   = BW'(op - base_full[ADDR_W-1:0]);

endmodule

// ----- hw/rtl/can_display_value_client_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_display_value_client_core
// client side of a can display protocol with a presence map in block memory
// ----------------------------------------------------------------------------
// usage
//   input: drive in_word and raise start; the word is taken at a rising edge
//   where start is high and busy is low. kind 0 is a received frame, kind 1
//   asks for the next registered address, kind 2 asks for target_addr.
//   output: every word gives exactly one result on out_word, shown for one
//   cycle with out_strobe high. the receiver cannot stall, so the result
//   register is simply overwritten by the next result.
//   config: cfg_wr_en with cfg_wr_data loads base_id; write only while idle.
// sequence
//   plain frames and requests: result in the cycle after acceptance.
//   register frames (offset 15): split address, read, update, then result.
//   next-address scan: n map words read, at most MAP_WORDS, through the
//   single read port of the map memory, one word per cycle.
// throughput
//   plain frames and requests: one word per cycle while busy is low. a
//   register frame keeps busy high through its split, read and update
//   steps, a scan until it finds a marked bit or examines its last word.
// reset
//   rst_n low returns the flags, the address and base_id to their reset
//   values, then a clearing pass writes zero to every map word, one per
//   cycle, with busy high. configuration writes are still
//   taken during the pass.
// ----------------------------------------------------------------------------
module can_display_value_client_core
  import cdvc_pkg::*;
#(
  parameter int MAP_WORDS = MAP_WORDS_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_word_t    in_word,
  output logic        out_strobe,
  output out_word_t   out_word,
  input  logic        cfg_wr_en,
  input  logic [10:0] cfg_wr_data
);

  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BW        = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam int MAP_BITS  = MAP_WORDS * WORD_BITS;
  localparam int LIMIT     = (MAP_BITS < ADDR_SPACE) ? MAP_BITS : ADDR_SPACE;
  localparam int SCAN_LAST = (LIMIT + WORD_BITS - 1) / WORD_BITS - 1;

  localparam logic [AW-1:0]     LAST_WORD = AW'(MAP_WORDS - 1);
  localparam logic [AW-1:0]     SCAN_END  = AW'(SCAN_LAST);
  localparam logic [ADDR_W:0]   LIMIT_V   = (ADDR_W + 1)'(LIMIT);
  localparam logic [ADDR_W-1:0] WB_STEP   = ADDR_W'(WORD_BITS);

  // one-hot sequencer states
  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_DIV   = 6'b000100,
    S_SPLIT = 6'b001000,
    S_MARK  = 6'b010000,
    S_SCAN  = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  logic [AW-1:0]       clr_cnt_r, clr_cnt_nxt;
  logic [10:0]         base_id_r;
  logic [ADDR_W-1:0]   cur_r, cur_nxt;
  logic                valid_r, valid_nxt;
  logic                wait_r, wait_nxt;
  logic [7:0]          msg_r, msg_nxt;
  logic [7:0]          ftype_r, ftype_nxt;
  logic [ADDR_W-1:0]   op_r, op_nxt;
  logic                scan_op_r, scan_op_nxt;
  logic [AW-1:0]       widx_r, widx_nxt;
  logic [ADDR_W-1:0]   wbase_r, wbase_nxt;
  logic [BW-1:0]       bit_lo_r, bit_lo_nxt;
  logic                out_strobe_r, out_strobe_nxt;
  out_word_t           out_word_r, out_word_nxt;

  // presence map memory, one write and one registered read port
  logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
  logic [WORD_BITS-1:0] rd_data_r;
  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic [WORD_BITS-1:0] mem_wdata;

  // address split unit
  logic [AW-1:0]        split_idx;
  logic [ADDR_W-1:0]    split_base;
  logic [BW-1:0]        split_bit;

  // per-item result fields
  logic                 fin;
  logic                 res_send, res_found, res_fresh;
  logic [2:0]           res_slot;
  logic [63:0]          res_text;

  // frame decode
  logic [10:0]          offset;
  logic                 id_hit;
  logic [15:0]          a16;
  logic [ADDR_W:0]      next_addr;

  // scan word search
  logic [WORD_BITS-1:0] masked;
  logic                 hit;
  logic [BW-1:0]        hit_idx;

  cdvc_addr_split #(
    .MAP_WORDS (MAP_WORDS),
    .WORD_BITS (WORD_BITS)
  ) u_split (
    .clk       (clk),
    .op        (op_r),
    .word_idx  (split_idx),
    .word_base (split_base),
    .bit_idx   (split_bit)
  );

  assign offset    = in_word.frame_id - base_id_r;
  assign id_hit    = (in_word.frame_id >= base_id_r);
  assign a16       = in_word.frame_data[15:0];
  assign next_addr = {1'b0, cur_r} + (ADDR_W + 1)'(1);

  // drop bits below the start position in the first scanned word, then
  // pick the lowest marked bit
  always_comb begin
    masked  = '0;
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      masked[i] = rd_data_r[i] && (i >= int'(bit_lo_r));
    end
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (masked[i]) begin
        hit     = 1'b1;
        hit_idx = BW'(i);
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    cur_nxt        = cur_r;
    valid_nxt      = valid_r;
    wait_nxt       = wait_r;
    msg_nxt        = msg_r;
    ftype_nxt      = ftype_r;
    op_nxt         = op_r;
    scan_op_nxt    = scan_op_r;
    widx_nxt       = widx_r;
    wbase_nxt      = wbase_r;
    bit_lo_nxt     = bit_lo_r;
    mem_we         = 1'b0;
    mem_waddr      = clr_cnt_r;
    mem_wdata      = '0;
    mem_re         = 1'b0;
    mem_raddr      = split_idx;
    fin            = 1'b0;
    res_send       = 1'b0;
    res_found      = 1'b0;
    res_fresh      = 1'b0;
    res_slot       = SLOT_NONE;
    res_text       = '0;

    case (state_r)
      S_CLEAR: begin
        mem_we      = 1'b1;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == LAST_WORD) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          case (in_word.kind)
            KIND_FRAME: begin
              fin = 1'b1;
              if (id_hit) begin
                case (offset)
                  OFF_REPLY: begin
                    if (a16 == {4'b0, cur_r}) begin
                      msg_nxt   = in_word.frame_data[23:16];
                      ftype_nxt = in_word.frame_data[31:24];
                      valid_nxt = 1'b1;
                      wait_nxt  = 1'b0;
                    end else begin
                      valid_nxt = 1'b0;
                    end
                  end
                  OFF_DESC1: if (valid_r) res_slot = SLOT_DESC1;
                  OFF_DESC2: if (valid_r) res_slot = SLOT_DESC2;
                  OFF_SUFFIX: if (valid_r) res_slot = SLOT_SUFFIX;
                  OFF_VALUE1: if (valid_r && !wait_r) res_slot = SLOT_VALUE1;
                  OFF_VALUE2: if (valid_r && !wait_r) res_slot = SLOT_VALUE2;
                  OFF_REGISTER: begin
                    // addresses beyond the map are dropped
                    if ({1'b0, a16} < 17'(LIMIT)) begin
                      fin         = 1'b0;
                      op_nxt      = a16[ADDR_W-1:0];
                      scan_op_nxt = 1'b0;
                      state_nxt   = S_DIV;
                    end
                  end
                  default: ;
                endcase
              end
              if (res_slot != SLOT_NONE) begin
                res_text = in_word.frame_data;
              end
            end
            KIND_NEXT: begin
              if (next_addr >= LIMIT_V) begin
                // already at the top of the map
                fin     = 1'b1;
                cur_nxt = '0;
              end else begin
                op_nxt      = next_addr[ADDR_W-1:0];
                scan_op_nxt = 1'b1;
                state_nxt   = S_DIV;
              end
            end
            KIND_GIVEN: begin
              fin      = 1'b1;
              res_send = 1'b1;
              cur_nxt  = in_word.target_addr;
              wait_nxt = 1'b1;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end

      S_DIV: begin
        // split unit registers the word index this cycle
        state_nxt = S_SPLIT;
      end

      S_SPLIT: begin
        mem_re     = 1'b1;
        mem_raddr  = split_idx;
        widx_nxt   = split_idx;
        wbase_nxt  = split_base;
        bit_lo_nxt = split_bit;
        state_nxt  = scan_op_r ? S_SCAN : S_MARK;
      end

      S_MARK: begin
        fin       = 1'b1;
        state_nxt = S_IDLE;
        if (!rd_data_r[split_bit]) begin
          mem_we    = 1'b1;
          mem_waddr = split_idx;
          mem_wdata = rd_data_r | (WORD_BITS'(1) << split_bit);
          res_fresh = 1'b1;
        end
      end

      S_SCAN: begin
        if (hit) begin
          fin       = 1'b1;
          res_found = 1'b1;
          res_send  = 1'b1;
          cur_nxt   = wbase_r + ADDR_W'(hit_idx);
          wait_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end else if (widx_r == SCAN_END) begin
          fin       = 1'b1;
          cur_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          mem_re     = 1'b1;
          mem_raddr  = widx_r + AW'(1);
          widx_nxt   = widx_r + AW'(1);
          wbase_nxt  = wbase_r + WB_STEP;
          bit_lo_nxt = '0;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    out_strobe_nxt                = fin;
    out_word_nxt.request_send     = res_send;
    out_word_nxt.request_addr     = cur_nxt;
    out_word_nxt.scan_found       = res_found;
    out_word_nxt.newly_registered = res_fresh;
    out_word_nxt.text_slot        = res_slot;
    out_word_nxt.text_bytes       = res_text;
    out_word_nxt.reply_valid      = valid_nxt;
    out_word_nxt.awaiting_reply   = wait_nxt;
    out_word_nxt.message_type     = msg_nxt;
    out_word_nxt.frame_type       = ftype_nxt;
  end

  // map memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= map_mem[mem_raddr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_cnt_r    <= '0;
      base_id_r    <= BASE_ID_RESET;
      cur_r        <= '0;
      valid_r      <= 1'b0;
      wait_r       <= 1'b1;
      msg_r        <= '0;
      ftype_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      cur_r        <= cur_nxt;
      valid_r      <= valid_nxt;
      wait_r       <= wait_nxt;
      msg_r        <= msg_nxt;
      ftype_r      <= ftype_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_wr_en) begin
        base_id_r <= cfg_wr_data;
      end
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    scan_op_r  <= scan_op_nxt;
    widx_r     <= widx_nxt;
    wbase_r    <= wbase_nxt;
    bit_lo_r   <= bit_lo_nxt;
    out_word_r <= out_word_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

  // map is written only by the clearing pass or a register frame
  assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_CLEAR || state_r == S_MARK))
    else $error("map write outside clear or mark");

  // a found scan always issues a request
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_word_r.scan_found) |-> out_word_r.request_send)
    else $error("scan found without request");

  // a fresh registration comes only out of the mark step
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_word_r.newly_registered) |-> $past(state_r) == S_MARK)
    else $error("fresh registration without mark step");

  // the scan never walks past the last word that covers an address
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (widx_r <= SCAN_END))
    else $error("scan beyond map limit");

endmodule

// ----- verif/can_display_value_client_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_display_value_client_checker
// watches the word and result channels of the display value client, keeps
// its own copy of the client state and presence map, works out the result of
// every accepted word and compares it field by field with the block's output
// ----------------------------------------------------------------------------
module can_display_value_client_checker
  import cdvc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  in_word_t    in_word,
  input  logic        out_strobe,
  input  out_word_t   out_word,
  input  logic        cfg_wr_en,
  input  logic [10:0] cfg_wr_data,
  output int          fail_count,
  output int          pending
);

  localparam int MAP_BITS  = MAP_WORDS_DEF * WORD_BITS_DEF;
  localparam int MAP_LIMIT = (MAP_BITS < ADDR_SPACE) ? MAP_BITS : ADDR_SPACE;

  logic [WORD_BITS_DEF-1:0] marked [MAP_WORDS_DEF];
  logic [ADDR_W-1:0]        cur_addr;
  logic                     valid_q;
  logic                     waiting_q;
  logic [7:0]               msg_type_q;
  logic [7:0]               frm_type_q;
  logic [10:0]              base_q;
  out_word_t                pending_results [$];
  out_word_t                want;

  initial fail_count = 0;

  function automatic logic is_marked(int a);
    return marked[a / WORD_BITS_DEF][a % WORD_BITS_DEF];
  endfunction

  // result of one word, updating the client state on the way
  function automatic out_word_t client_response(in_word_t w);
    out_word_t   r;
    logic [10:0] off;
    logic [15:0] a16;
    int          a;
    r   = '0;
    a16 = w.frame_data[15:0];
    if (w.kind == KIND_FRAME && w.frame_id >= base_q) begin
      off = w.frame_id - base_q;
      case (off)
        OFF_REPLY: begin
          if (a16 == {4'd0, cur_addr}) begin
            msg_type_q = w.frame_data[23:16];
            frm_type_q = w.frame_data[31:24];
            valid_q    = 1'b1;
            waiting_q  = 1'b0;
          end else begin
            valid_q = 1'b0;
          end
        end
        OFF_DESC1:  if (valid_q) r.text_slot = SLOT_DESC1;
        OFF_DESC2:  if (valid_q) r.text_slot = SLOT_DESC2;
        OFF_SUFFIX: if (valid_q) r.text_slot = SLOT_SUFFIX;
        OFF_VALUE1: if (valid_q && !waiting_q) r.text_slot = SLOT_VALUE1;
        OFF_VALUE2: if (valid_q && !waiting_q) r.text_slot = SLOT_VALUE2;
        OFF_REGISTER: begin
          if (a16 < MAP_LIMIT && !is_marked(int'(a16))) begin
            marked[a16 / WORD_BITS_DEF][a16 % WORD_BITS_DEF] = 1'b1;
            r.newly_registered = 1'b1;
          end
        end
        default: ;
      endcase
      if (r.text_slot != SLOT_NONE) r.text_bytes = w.frame_data;
    end else if (w.kind == KIND_NEXT) begin
      a = int'(cur_addr) + 1;
      while (a < MAP_LIMIT && !is_marked(a)) a++;
      if (a < MAP_LIMIT) begin
        cur_addr       = ADDR_W'(a);
        waiting_q      = 1'b1;
        r.scan_found   = 1'b1;
        r.request_send = 1'b1;
      end else begin
        cur_addr = '0;
      end
    end else if (w.kind == KIND_GIVEN) begin
      cur_addr       = w.target_addr;
      waiting_q      = 1'b1;
      r.request_send = 1'b1;
    end
    r.request_addr   = cur_addr;
    r.reply_valid    = valid_q;
    r.awaiting_reply = waiting_q;
    r.message_type   = msg_type_q;
    r.frame_type     = frm_type_q;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t ns: %s expected %h, got %h", $time, name, exp_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAP_WORDS_DEF; i++) marked[i] = '0;
      cur_addr   = '0;
      valid_q    = 1'b0;
      waiting_q  = 1'b1;
      msg_type_q = '0;
      frm_type_q = '0;
      base_q     = BASE_ID_RESET;
      pending_results.delete();
      pending <= 0;
    end else begin
      if (out_strobe) begin
        if (pending_results.size() == 0) begin
          $display("%0t ns: result word with none expected, got %h", $time, out_word);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("request_send", 64'(want.request_send),
                      64'(out_word.request_send));
          check_field("request_addr", 64'(want.request_addr),
                      64'(out_word.request_addr));
          check_field("scan_found", 64'(want.scan_found), 64'(out_word.scan_found));
          check_field("newly_registered", 64'(want.newly_registered),
                      64'(out_word.newly_registered));
          check_field("text_slot", 64'(want.text_slot), 64'(out_word.text_slot));
          check_field("text_bytes", want.text_bytes, out_word.text_bytes);
          check_field("reply_valid", 64'(want.reply_valid), 64'(out_word.reply_valid));
          check_field("awaiting_reply", 64'(want.awaiting_reply),
                      64'(out_word.awaiting_reply));
          check_field("message_type", 64'(want.message_type),
                      64'(out_word.message_type));
          check_field("frame_type", 64'(want.frame_type), 64'(out_word.frame_type));
        end
      end
      if (start && !busy) pending_results.push_back(client_response(in_word));
      if (cfg_wr_en) base_q = cfg_wr_data;
      pending <= pending_results.size();
    end
  end

endmodule

// ----- verif/can_display_value_client_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_display_value_client_core_tb
// drives the display value client with a short directed list and then random
// request / reply / text / register traffic under several base identifiers;
// the checker beside the block predicts and compares every result word
// ----------------------------------------------------------------------------
module can_display_value_client_core_tb;
  import cdvc_pkg::*;

  localparam int          CYCLE_LIMIT  = 1_500_000;
  localparam int          RANDOM_WORDS = 1100;
  // the package names only the three used kinds
  localparam logic [1:0]  KIND_UNUSED  = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_word_t    in_word;
  logic        out_strobe;
  out_word_t   out_word;
  logic        cfg_wr_en;
  logic [10:0] cfg_wr_data;

  int          fail_count;
  int          pending;
  int          cycles;
  int          counted;
  int          idle_pct;
  logic [10:0] cur_base;
  logic [11:0] seen_addr;
  logic [11:0] known_addrs [$];
  logic [10:0] phase_base [6];
  int          phase_end [6];

  can_display_value_client_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_word     (in_word),
    .out_strobe  (out_strobe),
    .out_word    (out_word),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  can_display_value_client_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_word     (in_word),
    .out_strobe  (out_strobe),
    .out_word    (out_word),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  always #5 clk = ~clk;

  // hard stop in case the block hangs or stops producing results
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // last reported address, so a reply can follow a next-address scan
  always @(posedge clk) begin
    if (rst_n && out_strobe) seen_addr <= out_word.request_addr;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // random payload with the 16-bit address in bytes 0 and 1
  function automatic logic [63:0] addr_data(logic [15:0] a);
    logic [63:0] d;
    d       = rand64();
    d[15:0] = a;
    return d;
  endfunction

  function automatic in_word_t make_word(logic [1:0] kind, logic [10:0] fid,
                                         logic [63:0] data, logic [11:0] target);
    in_word_t w;
    w.kind        = kind;
    w.frame_id    = fid;
    w.frame_data  = data;
    w.target_addr = target;
    return w;
  endfunction

  // identifier at an offset from the current base, wrapping at 11 bits
  function automatic logic [10:0] id_at(logic [10:0] off);
    return cur_base + off;
  endfunction

  // every task leaves the process just after a falling edge; start is only
  // lowered by the tasks that pause, so back-to-back words keep it high
  task automatic idle_gap(input int n);
    start <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // hold off until every predicted result has come back
  task automatic wait_results();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // block fully idle: nothing outstanding, not busy, plus a short settle
  task automatic drain();
    wait_results();
    while (busy) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic send_word(input in_word_t w, input bit counts);
    in_word <= w;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    if (counts) counted++;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
      idle_gap($urandom_range(1, 12));
    else if ($urandom_range(0, 59) == 0)
      wait_results();
  endtask

  task automatic write_base(input logic [10:0] v);
    cfg_wr_data <= v;
    cfg_wr_en   <= 1'b1;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    cur_base     = v;
  endtask

  // one text word at a random text offset
  task automatic text_frame();
    logic [10:0] off;
    off = OFF_DESC1 + 11'($urandom_range(0, 4));
    send_word(make_word(KIND_FRAME, id_at(off), rand64(), 12'($urandom)), 1);
  endtask

  // a few offset-15 words: mostly fresh addresses, some repeats, some beyond
  // the map
  task automatic register_burst();
    logic [15:0] a;
    int          n;
    n = $urandom_range(1, 4);
    repeat (n) begin
      case ($urandom_range(0, 9))
        0: a = 16'($urandom_range(ADDR_SPACE, 65535));
        1: a = (known_addrs.size() > 0) ?
               {4'd0, known_addrs[$urandom_range(0, known_addrs.size() - 1)]} :
               16'($urandom_range(0, ADDR_SPACE - 1));
        default: a = 16'($urandom_range(0, ADDR_SPACE - 1));
      endcase
      if (a < ADDR_SPACE) known_addrs.push_back(a[11:0]);
      send_word(make_word(KIND_FRAME, id_at(OFF_REGISTER), addr_data(a),
                          12'($urandom)), 1);
    end
  endtask

  // request, optional early text, reply (mostly matching), then text words
  task automatic run_exchange();
    logic [11:0] addr;
    logic [15:0] reply_a;
    if ($urandom_range(0, 1) == 1) begin
      if (known_addrs.size() > 0 && $urandom_range(0, 2) == 0)
        addr = known_addrs[$urandom_range(0, known_addrs.size() - 1)];
      else
        addr = 12'($urandom);
      send_word(make_word(KIND_GIVEN, 11'($urandom), rand64(), addr), 1);
    end else begin
      send_word(make_word(KIND_NEXT, 11'($urandom), rand64(), 12'($urandom)), 1);
      // the scan picks the address, so learn it before replying
      wait_results();
      addr = seen_addr;
    end
    // text while the reply is still outstanding
    if ($urandom_range(0, 4) == 0) text_frame();
    reply_a = {4'd0, addr};
    if ($urandom_range(0, 6) == 0) reply_a = reply_a ^ (16'd1 << $urandom_range(0, 15));
    send_word(make_word(KIND_FRAME, id_at(OFF_REPLY), addr_data(reply_a),
                        12'($urandom)), 1);
    repeat ($urandom_range(1, 6)) text_frame();
  endtask

  // words the block ignores or that are fully random; not counted
  task automatic send_noise();
    logic [10:0] fid;
    case ($urandom_range(0, 3))
      0: send_word(make_word(KIND_UNUSED, 11'($urandom), rand64(), 12'($urandom)), 0);
      1: begin
        // identifier below the base, no wrap into the offsets
        fid = (cur_base != 0) ? 11'($urandom_range(0, cur_base - 1)) : 11'($urandom);
        send_word(make_word(KIND_FRAME, fid, addr_data({4'd0, seen_addr}),
                            12'($urandom)), 0);
      end
      2: begin
        case ($urandom_range(0, 2))
          0:       fid = id_at(11'd0);
          1:       fid = id_at(11'($urandom_range(7, 14)));
          default: fid = id_at(11'($urandom_range(16, 2047)));
        endcase
        send_word(make_word(KIND_FRAME, fid, rand64(), 12'($urandom)), 0);
      end
      default: send_word(make_word(2'($urandom), 11'($urandom), rand64(),
                                   12'($urandom)), 0);
    endcase
  endtask

  initial begin
    int r;
    clk         = 1'b0;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_word     = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    cycles      = 0;
    counted     = 0;
    idle_pct    = 20;
    cur_base    = BASE_ID_RESET;

    // base per phase: reset value, both extremes, a random one, one where
    // offset 15 lands on the top identifier, and the reset value again
    phase_base[0] = BASE_ID_RESET;
    phase_base[1] = 11'h000;
    phase_base[2] = 11'h7FF;
    phase_base[3] = 11'($urandom);
    phase_base[4] = 11'h7F0;
    phase_base[5] = BASE_ID_RESET;
    phase_end[0]  = 220;
    phase_end[1]  = 420;
    phase_end[2]  = 460;
    phase_end[3]  = 660;
    phase_end[4]  = 860;
    phase_end[5]  = RANDOM_WORDS;

    // synchronous reset, then the map clearing pass holds busy high
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // directed words at the reset base
    // scan of an empty map, then the unused kind with every bit set
    send_word(make_word(KIND_NEXT, 11'h7FF, '1, 12'hFFF), 1);
    send_word(make_word(KIND_UNUSED, 11'h7FF, '1, 12'hFFF), 1);
    // register address 0 twice, the top address, and two beyond the map
    send_word(make_word(KIND_FRAME, id_at(OFF_REGISTER), 64'hFFFF_FFFF_FFFF_0000,
                        12'hFFF), 1);
    send_word(make_word(KIND_FRAME, id_at(OFF_REGISTER), 64'hFFFF_FFFF_FFFF_0000,
                        12'h000), 1);
    send_word(make_word(KIND_FRAME, id_at(OFF_REGISTER), addr_data(16'h0FFF), '0), 1);
    send_word(make_word(KIND_FRAME, id_at(OFF_REGISTER), addr_data(16'h1000), '0), 1);
    send_word(make_word(KIND_FRAME, id_at(OFF_REGISTER), addr_data(16'hFFFF), '0), 1);
    // text before any valid reply is dropped
    send_word(make_word(KIND_FRAME, id_at(OFF_DESC1), '1, '0), 1);
    // matching reply for address 0, then every text slot
    send_word(make_word(KIND_FRAME, id_at(OFF_REPLY), 64'hFFFF_FFFF_A55A_0000, '0), 1);
    send_word(make_word(KIND_FRAME, id_at(OFF_VALUE1), '1, '0), 1);
    send_word(make_word(KIND_FRAME, id_at(OFF_VALUE2), '0, '1), 1);
    send_word(make_word(KIND_FRAME, id_at(OFF_DESC1), rand64(), '0), 1);
    send_word(make_word(KIND_FRAME, id_at(OFF_DESC2), rand64(), '0), 1);
    send_word(make_word(KIND_FRAME, id_at(OFF_SUFFIX), rand64(), '0), 1);
    // new request keeps valid but blocks the value slots until the reply
    send_word(make_word(KIND_GIVEN, '0, '0, 12'hFFF), 1);
    send_word(make_word(KIND_FRAME, id_at(OFF_VALUE2), rand64(), '0), 1);
    send_word(make_word(KIND_FRAME, id_at(OFF_DESC2), rand64(), '0), 1);
    // reply address with a set upper nibble does not match, valid drops
    send_word(make_word(KIND_FRAME, id_at(OFF_REPLY), addr_data(16'h1FFF), '0), 1);
    send_word(make_word(KIND_FRAME, id_at(OFF_SUFFIX), rand64(), '0), 1);
    // scan from the top address finds nothing, from 0 it reaches the last
    // map word
    send_word(make_word(KIND_NEXT, '0, '0, '0), 1);
    send_word(make_word(KIND_NEXT, '0, '0, '0), 1);
    // identifier just below the base, then unused offsets
    send_word(make_word(KIND_FRAME, cur_base - 11'd1, addr_data(16'h0FFF), '0), 1);
    send_word(make_word(KIND_FRAME, id_at(11'd0), rand64(), '0), 1);
    send_word(make_word(KIND_FRAME, id_at(11'd7), rand64(), '0), 1);
    send_word(make_word(KIND_FRAME, id_at(11'd16), rand64(), '0), 1);
    send_word(make_word(KIND_GIVEN, '1, '1, 12'h000), 1);

    // random traffic, one base per phase, written while idle
    counted = 0;
    for (int p = 0; p < 6; p++) begin
      drain();
      write_base(phase_base[p]);
      while (counted < phase_end[p]) begin
        // change the idling density now and then, none at the very end
        if ($urandom_range(0, 14) == 0) begin
          case ($urandom_range(0, 2))
            0:       idle_pct = 0;
            1:       idle_pct = 15;
            default: idle_pct = 50;
          endcase
        end
        if (counted >= RANDOM_WORDS - 150) idle_pct = 0;
        r = $urandom_range(0, 99);
        if (r < 30)      register_burst();
        else if (r < 75) run_exchange();
        else if (r < 88) repeat ($urandom_range(1, 3)) text_frame();
        else             send_noise();
      end
    end

    // let the last scan finish and catch any stray result
    drain();
    repeat (300) @(negedge clk);
    if (fail_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
